### rtl/ppid_pkg.sv
// ----------------------------------------------------------------------------
// ppid_pkg
// Shared types and constants for the positional PID controller with deadband.
// ----------------------------------------------------------------------------
package ppid_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 16;            // setpoint / measured width
  localparam int ERR_W    = SAMPLE_W + 1;  // error width
  localparam int DERR_W   = SAMPLE_W + 2;  // error change width
  localparam int GAIN_W   = 16;
  localparam int DRIVE_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_UPPER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LOWER = 3'd5;

  // Register reset values
  localparam logic [GAIN_W-1:0]         GAIN_PROP_RST   = 16'd3;
  localparam logic [GAIN_W-1:0]         GAIN_INTEG_RST  = 16'd1;
  localparam logic [GAIN_W-1:0]         GAIN_DERIV_RST  = 16'd0;
  localparam logic [GAIN_W-1:0]         DEAD_BAND_RST   = 16'd3;
  localparam logic signed [DRIVE_W-1:0] DRIVE_UPPER_RST = 16'sd1800;
  localparam logic signed [DRIVE_W-1:0] DRIVE_LOWER_RST = -16'sd1800;

  // Operation codes
  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic                         op;
    logic signed [SAMPLE_W-1:0]   setpoint;
    logic signed [SAMPLE_W-1:0]   measured;
  } pid_in_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0]    drive;
    logic                         held;
    logic                         clamped;
  } pid_out_t;

  typedef struct packed {
    logic [GAIN_W-1:0]            gain_prop;
    logic [GAIN_W-1:0]            gain_integ;
    logic [GAIN_W-1:0]            gain_deriv;
    logic [GAIN_W-1:0]            dead_band;
    logic signed [DRIVE_W-1:0]    drive_upper;
    logic signed [DRIVE_W-1:0]    drive_lower;
  } pid_cfg_t;

endpackage

### rtl/ppid_cfg_regs.sv
// ----------------------------------------------------------------------------
// ppid_cfg_regs
// Configuration register file: gains, deadband and drive limits.
// ----------------------------------------------------------------------------
module ppid_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [ppid_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [ppid_pkg::CFG_DAT_W-1:0]     wr_data,
  output ppid_pkg::pid_cfg_t                 cfg
);

  ppid_pkg::pid_cfg_t cfg_r;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_prop   <= ppid_pkg::GAIN_PROP_RST;
      cfg_r.gain_integ  <= ppid_pkg::GAIN_INTEG_RST;
      cfg_r.gain_deriv  <= ppid_pkg::GAIN_DERIV_RST;
      cfg_r.dead_band   <= ppid_pkg::DEAD_BAND_RST;
      cfg_r.drive_upper <= ppid_pkg::DRIVE_UPPER_RST;
      cfg_r.drive_lower <= ppid_pkg::DRIVE_LOWER_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        ppid_pkg::REG_GAIN_PROP:   cfg_r.gain_prop   <= wr_data;
        ppid_pkg::REG_GAIN_INTEG:  cfg_r.gain_integ  <= wr_data;
        ppid_pkg::REG_GAIN_DERIV:  cfg_r.gain_deriv  <= wr_data;
        ppid_pkg::REG_DEAD_BAND:   cfg_r.dead_band   <= wr_data;
        ppid_pkg::REG_DRIVE_UPPER: cfg_r.drive_upper <= $signed(wr_data);
        ppid_pkg::REG_DRIVE_LOWER: cfg_r.drive_lower <= $signed(wr_data);
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/ppid_datapath.sv
// ----------------------------------------------------------------------------
// ppid_datapath
// Single-pass PID step: error, integral, weighted sum, deadband and clamp; a clear op zeroes state and result.
// ----------------------------------------------------------------------------
module ppid_datapath #(
  parameter int SUM_WIDTH = 32
) (
  input  ppid_pkg::pid_in_t                      item,
  input  ppid_pkg::pid_cfg_t                     cfg,
  input  logic signed [ppid_pkg::ERR_W-1:0]      last_error,
  input  logic signed [SUM_WIDTH-1:0]            error_sum,
  input  logic signed [ppid_pkg::DRIVE_W-1:0]    last_drive,
  output logic signed [ppid_pkg::ERR_W-1:0]      last_error_nxt,
  output logic signed [SUM_WIDTH-1:0]            error_sum_nxt,
  output logic signed [ppid_pkg::DRIVE_W-1:0]    last_drive_nxt,
  output ppid_pkg::pid_out_t                     result
);

  localparam int EW   = ppid_pkg::ERR_W;
  localparam int DEW  = ppid_pkg::DERR_W;
  localparam int GW   = ppid_pkg::GAIN_W + 1;           // gain as signed
  localparam int AW   = ((SUM_WIDTH > EW) ? SUM_WIDTH : EW) + 1;
  localparam int PPW  = GW + EW;                       // prop product
  localparam int PIW  = GW + SUM_WIDTH;                // integ product
  localparam int PDW  = GW + DEW;                      // deriv product
  localparam int PMW  = (PIW > PDW) ? PIW : PDW;
  localparam int TW   = PMW + 2;                       // total, no overflow
  localparam int CW   = TW - 1;                        // total >>> 1

  logic signed [EW-1:0]        err;
  logic signed [DEW-1:0]       derr;
  logic signed [AW-1:0]        sum_wide;
  logic signed [SUM_WIDTH-1:0] sum_sat;
  logic                        sum_ovf;
  logic [EW-1:0]               err_mag;
  logic                        in_band;
  logic signed [PPW-1:0]       p_prop;
  logic signed [PIW-1:0]       p_integ;
  logic signed [PDW-1:0]       p_deriv;
  logic signed [TW-1:0]        total;
  logic signed [CW-1:0]        cand;
  logic signed [CW-1:0]        lim_up;
  logic signed [CW-1:0]        lim_lo;
  logic signed [ppid_pkg::DRIVE_W-1:0] drive;
  logic                        clamped;

  // Error and error change
  assign err  = EW'(item.setpoint) - EW'(item.measured);
  assign derr = DEW'(err) - DEW'(last_error);

  // Integral with saturation at SUM_WIDTH bits
  assign sum_wide = AW'(error_sum) + AW'(err);
  assign sum_ovf  = (sum_wide[AW-1:SUM_WIDTH-1] != '0) &&
                    (sum_wide[AW-1:SUM_WIDTH-1] != '1);
  always_comb begin
    if (sum_ovf) begin
      sum_sat = sum_wide[AW-1] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                               : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_WIDTH-1:0];
    end
  end

  // Deadband test on error magnitude
  assign err_mag = err[EW-1] ? EW'(-err) : EW'(err);
  assign in_band = err_mag < EW'({1'b0, cfg.dead_band});

  // Gain terms, full width
  assign p_prop  = $signed({1'b0, cfg.gain_prop})  * err;
  assign p_integ = $signed({1'b0, cfg.gain_integ}) * sum_sat;
  assign p_deriv = $signed({1'b0, cfg.gain_deriv}) * derr;
  assign total   = TW'(p_prop) + TW'(p_integ) + TW'(p_deriv);

  // Candidate drive: held value or floor(total / 2)
  assign cand   = in_band ? CW'(last_drive) : total[TW-1:1];
  assign lim_up = CW'(cfg.drive_upper);
  assign lim_lo = CW'(cfg.drive_lower);

  // Clamp, upper limit checked first
  always_comb begin
    priority if (cand >= lim_up) begin
      drive   = cfg.drive_upper;
      clamped = 1'b1;
    end else if (cand <= lim_lo) begin
      drive   = cfg.drive_lower;
      clamped = 1'b1;
    end else begin
      drive   = cand[ppid_pkg::DRIVE_W-1:0];
      clamped = 1'b0;
    end
  end

  // Clear op zeroes state and result
  always_comb begin
    if (item.op == ppid_pkg::OP_CLEAR) begin
      last_error_nxt = '0;
      error_sum_nxt  = '0;
      last_drive_nxt = '0;
      result.drive   = '0;
      result.held    = 1'b0;
      result.clamped = 1'b0;
    end else begin
      last_error_nxt = err;
      error_sum_nxt  = sum_sat;
      last_drive_nxt = drive;
      result.drive   = drive;
      result.held    = in_band;
      result.clamped = clamped;
    end
  end

endmodule

### rtl/positional_pid_deadband_core.sv
// ----------------------------------------------------------------------------
// positional_pid_deadband_core
// Positional PID speed controller with deadband and drive clamp.
// ----------------------------------------------------------------------------
//  channel | ports                               | transfer when
//  --------+-------------------------------------+---------------------------
//  input   | in_valid, in_stall, in_data         | in_valid && !in_stall
//  result  | out_valid, out_stall, out_data      | out_valid && !out_stall
//  config  | cfg_valid, cfg_ready, cfg_index/data| cfg_valid && cfg_ready
//
// One transaction per cycle sustained while the result is not stalled; a result
// passes through the input register, then the result register, before it
// leaves. The combinational PID step with its three gain multiplies sits
// between those two registers.
// Reset is synchronous and active low; it restores register defaults and
// zeroes the controller state. A stalled result holds the pipe; the input
// register still takes one more transaction while the result waits.
module positional_pid_deadband_core #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ppid_pkg::pid_in_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ppid_pkg::pid_out_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppid_pkg::CFG_DAT_W-1:0]    cfg_data
);

  ppid_pkg::pid_cfg_t cfg;
  ppid_pkg::pid_in_t  item_r;
  ppid_pkg::pid_out_t result;
  ppid_pkg::pid_out_t out_r;
  logic               item_vld_r;
  logic               out_vld_r;
  logic               adv;
  logic               take;

  logic signed [ppid_pkg::ERR_W-1:0]   last_error_r;
  logic signed [SUM_WIDTH-1:0]         error_sum_r;
  logic signed [ppid_pkg::DRIVE_W-1:0] last_drive_r;
  logic signed [ppid_pkg::ERR_W-1:0]   last_error_nxt;
  logic signed [SUM_WIDTH-1:0]         error_sum_nxt;
  logic signed [ppid_pkg::DRIVE_W-1:0] last_drive_nxt;

  // Configuration registers
  assign cfg_ready = 1'b1;

  ppid_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Pipeline flow control
  assign adv      = item_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = item_vld_r && !adv;
  assign take     = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (take) begin
      item_vld_r <= 1'b1;
    end else if (adv) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_data;
    end
  end

  // PID step
  ppid_datapath #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_dp (
    .item           (item_r),
    .cfg            (cfg),
    .last_error     (last_error_r),
    .error_sum      (error_sum_r),
    .last_drive     (last_drive_r),
    .last_error_nxt (last_error_nxt),
    .error_sum_nxt  (error_sum_nxt),
    .last_drive_nxt (last_drive_nxt),
    .result         (result)
  );

  // Controller state, updated as each transaction moves to the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r <= '0;
      error_sum_r  <= '0;
      last_drive_r <= '0;
    end else if (adv) begin
      last_error_r <= last_error_nxt;
      error_sum_r  <= error_sum_nxt;
      last_drive_r <= last_drive_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
